[hdl/cetr_pkg.sv]
// shared types, register-file addresses and the micro-program of the cubic escape-time unit
`default_nettype none

package cetr_pkg;

    typedef enum logic [3:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_SCL2,
        OP_SCL3,
        OP_SCL100,
        OP_DIV,
        OP_DIVT,
        OP_SQRT,
        OP_CHKLIM,
        OP_GE,
        OP_NEXT,
        OP_CHKOVF,
        OP_SIDE
    } t_op;

    typedef logic [4:0] t_addr;
    typedef logic [5:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_addr dst;
        t_addr src_a;
        t_addr src_b;
    } t_uop;

    localparam t_addr R_CRE  = 5'd0;
    localparam t_addr R_CIM  = 5'd1;
    localparam t_addr R_M    = 5'd2;
    localparam t_addr R_SRE  = 5'd3;
    localparam t_addr R_SIM  = 5'd4;
    localparam t_addr R_ARE  = 5'd5;
    localparam t_addr R_AIM  = 5'd6;
    localparam t_addr R_MAG2 = 5'd7;
    localparam t_addr R_DEN  = 5'd8;
    localparam t_addr R_ZR   = 5'd9;
    localparam t_addr R_ZI   = 5'd10;
    localparam t_addr R_R    = 5'd11;
    localparam t_addr R_RAD  = 5'd13;
    localparam t_addr R_T0   = 5'd14;
    localparam t_addr R_T1   = 5'd15;
    localparam t_addr R_T2   = 5'd16;
    localparam t_addr R_T3   = 5'd17;
    localparam t_addr R_T4   = 5'd18;
    localparam t_addr R_T5   = 5'd19;
    localparam t_addr R_T6   = 5'd20;
    localparam t_addr R_T7   = 5'd21;
    localparam t_addr R_ZERO = 5'd30;
    localparam t_addr R_ONE  = 5'd31;

    localparam t_pc LOOP_PC = 6'd26;
    localparam t_pc SIDE_PC = 6'd51;

    function automatic t_uop prog_at(input t_pc pc);
        t_uop u;
        case (pc)
            // setup: s = 1/c, a = s^2, z0, escape bound
            6'd0:  u = '{OP_MUL,    R_T0,   R_CRE,  R_CRE};
            6'd1:  u = '{OP_MUL,    R_T1,   R_CIM,  R_CIM};
            6'd2:  u = '{OP_ADD,    R_M,    R_T0,   R_T1};
            6'd3:  u = '{OP_DIV,    R_SRE,  R_CRE,  R_M};
            6'd4:  u = '{OP_SUB,    R_T0,   R_ZERO, R_CIM};
            6'd5:  u = '{OP_DIV,    R_SIM,  R_T0,   R_M};
            6'd6:  u = '{OP_MUL,    R_T0,   R_SRE,  R_SRE};
            6'd7:  u = '{OP_MUL,    R_T1,   R_SIM,  R_SIM};
            6'd8:  u = '{OP_SUB,    R_ARE,  R_T0,   R_T1};
            6'd9:  u = '{OP_MUL,    R_T0,   R_SRE,  R_SIM};
            6'd10: u = '{OP_SCL2,   R_AIM,  R_T0,   R_T0};
            6'd11: u = '{OP_MUL,    R_T0,   R_ARE,  R_ARE};
            6'd12: u = '{OP_MUL,    R_T1,   R_AIM,  R_AIM};
            6'd13: u = '{OP_ADD,    R_MAG2, R_T0,   R_T1};
            6'd14: u = '{OP_SCL3,   R_DEN,  R_MAG2, R_MAG2};
            6'd15: u = '{OP_ADD,    R_T0,   R_MAG2, R_ARE};
            6'd16: u = '{OP_SCL2,   R_T0,   R_T0,   R_T0};
            6'd17: u = '{OP_DIV,    R_ZR,   R_T0,   R_DEN};
            6'd18: u = '{OP_SCL2,   R_T1,   R_AIM,  R_AIM};
            6'd19: u = '{OP_SUB,    R_T1,   R_ZERO, R_T1};
            6'd20: u = '{OP_DIV,    R_ZI,   R_T1,   R_DEN};
            6'd21: u = '{OP_SQRT,   R_T0,   R_MAG2, R_MAG2};
            6'd22: u = '{OP_SQRT,   R_R,    R_T0,   R_T0};
            6'd23: u = '{OP_DIVT,   R_T0,   R_R,    R_R};
            6'd24: u = '{OP_ADD,    R_T0,   R_R,    R_T0};
            6'd25: u = '{OP_SCL100, R_RAD,  R_T0,   R_T0};
            // iteration loop
            6'd26: u = '{OP_CHKLIM, R_T0,   R_ZERO, R_ZERO};
            6'd27: u = '{OP_MUL,    R_T0,   R_ZR,   R_ZR};
            6'd28: u = '{OP_MUL,    R_T1,   R_ZI,   R_ZI};
            6'd29: u = '{OP_ADD,    R_T2,   R_T0,   R_T1};
            6'd30: u = '{OP_GE,     R_T2,   R_T2,   R_RAD};
            6'd31: u = '{OP_SUB,    R_T2,   R_T0,   R_T1};
            6'd32: u = '{OP_MUL,    R_T3,   R_ZR,   R_ZI};
            6'd33: u = '{OP_SCL2,   R_T3,   R_T3,   R_T3};
            6'd34: u = '{OP_MUL,    R_T4,   R_ARE,  R_ZR};
            6'd35: u = '{OP_MUL,    R_T5,   R_AIM,  R_ZI};
            6'd36: u = '{OP_SUB,    R_T4,   R_T4,   R_T5};
            6'd37: u = '{OP_SUB,    R_T4,   R_T4,   R_ARE};
            6'd38: u = '{OP_SUB,    R_T4,   R_T4,   R_ONE};
            6'd39: u = '{OP_MUL,    R_T5,   R_AIM,  R_ZR};
            6'd40: u = '{OP_MUL,    R_T6,   R_ARE,  R_ZI};
            6'd41: u = '{OP_ADD,    R_T5,   R_T5,   R_T6};
            6'd42: u = '{OP_SUB,    R_T5,   R_T5,   R_AIM};
            6'd43: u = '{OP_MUL,    R_T6,   R_T2,   R_T4};
            6'd44: u = '{OP_MUL,    R_T7,   R_T3,   R_T5};
            6'd45: u = '{OP_SUB,    R_T6,   R_T6,   R_T7};
            6'd46: u = '{OP_ADD,    R_ZR,   R_T6,   R_ONE};
            6'd47: u = '{OP_MUL,    R_T6,   R_T3,   R_T4};
            6'd48: u = '{OP_MUL,    R_T7,   R_T2,   R_T5};
            6'd49: u = '{OP_ADD,    R_ZI,   R_T6,   R_T7};
            6'd50: u = '{OP_NEXT,   R_T0,   R_ZERO, R_ZERO};
            // ray side after escape
            6'd51: u = '{OP_CHKOVF, R_T0,   R_ZERO, R_ZERO};
            6'd52: u = '{OP_MUL,    R_T0,   R_ZR,   R_SIM};
            6'd53: u = '{OP_MUL,    R_T1,   R_ZI,   R_SRE};
            6'd54: u = '{OP_ADD,    R_T0,   R_T0,   R_T1};
            6'd55: u = '{OP_SIDE,   R_T0,   R_T0,   R_T0};
            default: u = '{OP_SIDE, R_T0,   R_T0,   R_T0};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[hdl/cubic_escape_time_ray_unit.sv]
// top level: escape-time iteration of the cubic family with external-ray side coloring
`default_nettype none

// One parameter point c enters on the slave stream; one result leaves on the master
// stream. A small micro-program drives a shared datapath (a 32x32 multiplier stepped
// over four partial products, an adder, a bit-serial divider and a bit-serial square
// root) through a 32-entry register file. Setup is dominated by five 63-step divisions
// and two 64-step square roots; each iteration is set mostly by twelve products of four
// multiplier passes each. The unit is not ready while a point is in work; a finished
// result waits in the output register while the next point is accepted. max_iter is
// written through i_cfg_wen.
module cubic_escape_time_ray_unit
    import cetr_pkg::*;
#(
    parameter int FRAC_BITS = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wen,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [127:0]  i_s_axis_tdata,   // c_re[63:0], c_im[127:64]
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [39:0]        o_m_axis_tdata    // color_code[19:0], escaped[20], iter_count[36:21]
);

    localparam logic [63:0]  FX_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [127:0] TEN_NUM = 128'd10 << (2 * FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_MFIN, S_DCHK, S_DIV, S_SQRT, S_WB, S_DONE
    } t_state;

    t_state        r_state;
    t_pc           r_pc;
    logic [15:0]   r_max_iter;
    logic [15:0]   r_iter;
    logic          r_ovf;
    logic [63:0]   r_cre;
    logic [63:0]   r_cim;
    logic [63:0]   r_rda;
    logic [63:0]   r_rdb;
    logic [63:0]   r_res;
    logic [63:0]   r_ma;
    logic [63:0]   r_mb;
    logic          r_neg;
    logic          r_scl;
    logic [127:0]  r_acc;
    logic [127:0]  r_num;
    logic [63:0]   r_den;
    logic [67:0]   r_rem;
    logic [63:0]   r_root;
    logic [5:0]    r_cnt;
    logic          r_fin_esc;
    logic          r_fin_lower;
    logic          r_out_valid;
    logic [19:0]   r_out_color;
    logic          r_out_esc;
    logic [15:0]   r_out_iter;
    logic [63:0]   rf [32];

    t_uop          uop;
    logic [63:0]   va;
    logic [63:0]   vb;
    logic [63:0]   sum;
    logic [63:0]   dif;
    logic          sum_ovf;
    logic          dif_ovf;
    logic [31:0]   pa;
    logic [31:0]   pb;
    logic [63:0]   pp;
    logic [127:0]  pp_sh;
    logic [127:0]  mq;
    logic [63:0]   mval;
    logic          movf;
    logic [64:0]   drem;
    logic          dge;
    logic [67:0]   srem;
    logic [67:0]   strial;
    logic          sge;
    logic [19:0]   fin_color;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] opnd(input t_addr a, input logic [63:0] mem,
                                         input logic [63:0] cre, input logic [63:0] cim);
        logic [63:0] v;
        case (a)
            R_CRE:   v = cre;
            R_CIM:   v = cim;
            R_ZERO:  v = 64'd0;
            R_ONE:   v = FX_ONE;
            default: v = mem;
        endcase
        return v;
    endfunction

    always_comb begin
        uop     = prog_at(r_pc);
        va      = opnd(uop.src_a, r_rda, r_cre, r_cim);
        vb      = opnd(uop.src_b, r_rdb, r_cre, r_cim);
        sum     = va + vb;
        dif     = va - vb;
        sum_ovf = (va[63] == vb[63]) && (sum[63] != va[63]);
        dif_ovf = (va[63] != vb[63]) && (dif[63] != va[63]);
        pa      = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        pb      = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        pp      = 64'(pa) * 64'(pb);
        pp_sh   = {64'd0, pp} << ({6'd0, r_cnt[1]} + {6'd0, r_cnt[0]}) * 7'd32;
        mq      = r_scl ? r_acc : (r_acc >> FRAC_BITS);
        movf    = mq[127:63] != 65'd0;
        mval    = r_neg ? (64'd0 - mq[63:0]) : mq[63:0];
        drem    = {r_rem[63:0], r_num[127]};
        dge     = drem >= {1'b0, r_den};
        srem    = {r_rem[65:0], r_num[127:126]};
        strial  = {2'b00, r_root, 2'b01};
        sge     = srem >= strial;
        fin_color = r_fin_esc ? ({2'b00, r_iter, 2'b00} + (r_fin_lower ? 20'd11 : 20'd0))
                              : '1;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            rf[uop.dst] <= r_res;
        end
        r_rda <= rf[uop.src_a];
        r_rdb <= rf[uop.src_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_max_iter  <= 16'd100;
            r_iter      <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_fin_esc   <= 1'b0;
            r_fin_lower <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_max_iter <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cre   <= i_s_axis_tdata[63:0];
                        r_cim   <= i_s_axis_tdata[127:64];
                        r_ovf   <= 1'b0;
                        r_iter  <= '0;
                        r_pc    <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (uop.op)
                        OP_ADD: begin
                            r_res   <= sum;
                            r_ovf   <= r_ovf | sum_ovf;
                            r_state <= S_WB;
                        end
                        OP_SUB: begin
                            r_res   <= dif;
                            r_ovf   <= r_ovf | dif_ovf;
                            r_state <= S_WB;
                        end
                        OP_MUL, OP_SCL2, OP_SCL3, OP_SCL100: begin
                            r_ma  <= mag(va);
                            r_neg <= (uop.op == OP_MUL) ? (va[63] ^ vb[63]) : va[63];
                            r_scl <= uop.op != OP_MUL;
                            case (uop.op)
                                OP_SCL2:   r_mb <= 64'd2;
                                OP_SCL3:   r_mb <= 64'd3;
                                OP_SCL100: r_mb <= 64'd100;
                                default:   r_mb <= mag(vb);
                            endcase
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_MUL;
                        end
                        OP_DIV: begin
                            r_num   <= {64'd0, mag(va)} << FRAC_BITS;
                            r_den   <= mag(vb);
                            r_neg   <= va[63] ^ vb[63];
                            r_state <= S_DCHK;
                        end
                        OP_DIVT: begin
                            r_num   <= TEN_NUM;
                            r_den   <= mag(va);
                            r_neg   <= 1'b0;
                            r_state <= S_DCHK;
                        end
                        OP_SQRT: begin
                            if (va[63] || va == 64'd0) begin
                                r_res   <= '0;
                                r_state <= S_WB;
                            end else begin
                                r_num   <= {64'd0, va} << FRAC_BITS;
                                r_rem   <= '0;
                                r_root  <= '0;
                                r_cnt   <= 6'd63;
                                r_state <= S_SQRT;
                            end
                        end
                        OP_CHKLIM: begin
                            if (r_iter >= r_max_iter) begin
                                r_fin_esc   <= 1'b0;
                                r_fin_lower <= 1'b0;
                                r_state     <= S_DONE;
                            end else begin
                                r_pc    <= r_pc + 6'd1;
                                r_state <= S_READ;
                            end
                        end
                        OP_GE: begin
                            r_pc    <= (r_ovf || $signed(va) >= $signed(vb)) ? SIDE_PC
                                                                            : r_pc + 6'd1;
                            r_state <= S_READ;
                        end
                        OP_NEXT: begin
                            r_iter  <= r_iter + 16'd1;
                            r_pc    <= LOOP_PC;
                            r_state <= S_READ;
                        end
                        OP_CHKOVF: begin
                            if (r_ovf) begin
                                r_fin_esc   <= 1'b1;
                                r_fin_lower <= 1'b0;
                                r_state     <= S_DONE;
                            end else begin
                                r_pc    <= r_pc + 6'd1;
                                r_state <= S_READ;
                            end
                        end
                        OP_SIDE: begin
                            r_fin_esc   <= 1'b1;
                            r_fin_lower <= !r_ovf && va[63];
                            r_state     <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    r_res   <= mval;
                    r_ovf   <= r_ovf | movf;
                    r_state <= S_WB;
                end
                S_DCHK: begin
                    if (r_den == 64'd0 || r_num[127:63] >= {1'b0, r_den}) begin
                        r_ovf   <= 1'b1;
                        r_res   <= '0;
                        r_state <= S_WB;
                    end else begin
                        r_rem   <= {4'd0, r_num[126:63]};
                        r_num   <= {r_num[62:0], 65'd0};
                        r_root  <= '0;
                        r_cnt   <= 6'd62;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= dge ? {3'd0, drem - {1'b0, r_den}} : {3'd0, drem};
                    r_root <= {r_root[62:0], dge};
                    r_num  <= {r_num[126:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_res   <= r_neg ? (64'd0 - {r_root[62:0], dge}) : {r_root[62:0], dge};
                        r_state <= S_WB;
                    end
                end
                S_SQRT: begin
                    r_rem  <= sge ? (srem - strial) : srem;
                    r_root <= {r_root[62:0], sge};
                    r_num  <= {r_num[125:0], 2'b00};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_res   <= {r_root[62:0], sge};
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_READ;
                    r_pc    <= r_pc + 6'd1;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_color <= fin_color;
                        r_out_esc   <= r_fin_esc;
                        r_out_iter  <= r_iter;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_iter, r_out_esc, r_out_color};

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("unit ready right after taking an item");

    a_noesc_color : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_esc |-> r_out_color == 20'hFFFFF)
        else $error("non-escaping item without the no-escape color");

    a_noesc_iter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_esc |-> r_out_iter == r_max_iter)
        else $error("non-escaping item stopped before the iteration limit");

    a_iter_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_iter <= r_max_iter)
        else $error("iteration count passed the limit");

endmodule

`default_nettype wire
